### design/rfa_pkg.sv
// shared types, constants and register codes of the relay feedback autotuner
package rfa_pkg;

   localparam int unsigned PositionWidth   = 16;
   localparam int unsigned TimeWidth       = 32;
   localparam int unsigned MagWidth        = 15;
   localparam int unsigned TolWidth        = 8;
   localparam int unsigned CountWidth      = 4;
   localparam int unsigned CsrIndexWidth   = 3;
   localparam int unsigned CsrDataWidth    = 15;

   localparam logic [CountWidth-1:0] COUNT_MAX = '1;

   localparam logic [MagWidth-1:0]   RELAY_HEIGHT_RESET  = 15'd8192;
   localparam logic [MagWidth-1:0]   EFFORT_LIMIT_RESET  = 15'd32767;
   localparam logic [TolWidth-1:0]   AMP_TOL_RESET       = 8'd26;
   localparam logic [TolWidth-1:0]   PER_TOL_RESET       = 8'd26;
   localparam logic [CountWidth-1:0] CYCLES_NEEDED_RESET = 4'd5;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RELAY_HEIGHT  = 3'd0,
      CSR_EFFORT_LIMIT  = 3'd1,
      CSR_AMP_TOL       = 3'd2,
      CSR_PER_TOL       = 3'd3,
      CSR_CYCLES_NEEDED = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_SEEK_POS = 2'd0,
      PHASE_SEEK_NEG = 2'd1,
      PHASE_DONE     = 2'd2
   } phase_type;

   typedef struct packed {
      logic signed [PositionWidth-1:0] position;
      logic [TimeWidth-1:0]            sample_time;
   } req_type;

   typedef struct packed {
      logic signed [PositionWidth-1:0] effort;
      logic [1:0]                      phase;
      logic                            cycle_complete;
      logic [TimeWidth-1:0]            period;
      logic [MagWidth-1:0]             amplitude;
      logic [CountWidth-1:0]           matched_count;
   } rsp_type;

   typedef struct packed {
      logic [MagWidth-1:0]   relay_height;
      logic [MagWidth-1:0]   effort_limit;
      logic [TolWidth-1:0]   amplitude_tolerance;
      logic [TolWidth-1:0]   period_tolerance;
      logic [CountWidth-1:0] cycles_needed;
   } cfg_type;

   typedef struct packed {
      logic amp_ok;
      logic per_ok;
   } match_type;

endpackage

### design/relay_feedback_autotuner.sv
// top level of the relay feedback autotuner: registers, handshakes, core
//
// channel   direction  ports                         payload
// req       in         req_valid/req_ready           req_type (position, sample_time)
// rsp       out        rsp_valid/rsp_ready           rsp_type (effort .. matched_count)
// csr       in         csr_valid/csr_ready           csr_index, csr_data
//
// a sample moves req -> input register -> core logic -> result register
// rsp_valid comes after both registers; one sample per cycle unless rsp stalls
// the core state updates in the same cycle the result register loads
// a stalled rsp holds the result register and the input register behind it
// reset clears valids and core state, loads register defaults; csr is always ready
module relay_feedback_autotuner
   import rfa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    step;
   logic    req_xfer;

   // configuration registers, writes to unused indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_RELAY_HEIGHT:  cfg_in.relay_height        = csr_data[MagWidth-1:0];
            CSR_EFFORT_LIMIT:  cfg_in.effort_limit        = csr_data[MagWidth-1:0];
            CSR_AMP_TOL:       cfg_in.amplitude_tolerance = csr_data[TolWidth-1:0];
            CSR_PER_TOL:       cfg_in.period_tolerance    = csr_data[TolWidth-1:0];
            CSR_CYCLES_NEEDED: cfg_in.cycles_needed       = csr_data[CountWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relay_height        <= RELAY_HEIGHT_RESET;
         cfg_ff.effort_limit        <= EFFORT_LIMIT_RESET;
         cfg_ff.amplitude_tolerance <= AMP_TOL_RESET;
         cfg_ff.period_tolerance    <= PER_TOL_RESET;
         cfg_ff.cycles_needed       <= CYCLES_NEEDED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control: the result register loads when empty or drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      out_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= core_rsp;
      end
   end

   rfa_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### design/rfa_match.sv
// tolerance test of one closed period against the previous one
module rfa_match
   import rfa_pkg::*;
(
   input  logic [MagWidth-1:0]  amplitude,
   input  logic [MagWidth-1:0]  prev_amplitude,
   input  logic [TimeWidth-1:0] period,
   input  logic [TimeWidth-1:0] prev_period,
   input  logic [TolWidth-1:0]  amp_tol,
   input  logic [TolWidth-1:0]  per_tol,
   output match_type            match
);

   localparam int unsigned AmpProdWidth = MagWidth + TolWidth;
   localparam int unsigned PerProdWidth = TimeWidth + TolWidth;

   logic [MagWidth-1:0]     amp_diff;
   logic [TimeWidth-1:0]    per_diff;
   logic [AmpProdWidth-1:0] amp_lhs;
   logic [AmpProdWidth-1:0] amp_rhs;
   logic [PerProdWidth-1:0] per_lhs;
   logic [PerProdWidth-1:0] per_rhs;

   always_comb begin
      amp_diff = (amplitude > prev_amplitude) ? amplitude - prev_amplitude
                                              : prev_amplitude - amplitude;
      per_diff = (period > prev_period) ? period - prev_period
                                        : prev_period - period;
      // difference scaled by 256 against q0.8 tolerance times previous value
      amp_lhs = {amp_diff, {TolWidth{1'b0}}};
      per_lhs = {per_diff, {TolWidth{1'b0}}};
      amp_rhs = AmpProdWidth'(amp_tol) * AmpProdWidth'(prev_amplitude);
      per_rhs = PerProdWidth'(per_tol) * PerProdWidth'(prev_period);
      match.amp_ok = amp_lhs < amp_rhs;
      match.per_ok = per_lhs < per_rhs;
   end

endmodule

### design/rfa_core.sv
// relay state machine, peak tracking and period bookkeeping
module rfa_core
   import rfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type                       phase_ff, phase_in, phase_mid;
   logic [MagWidth-1:0]             high_peak_ff, high_peak_in;
   logic signed [PositionWidth-1:0] low_peak_ff, low_peak_in;
   logic [TimeWidth-1:0]            period_start_ff, period_start_in;
   logic [TimeWidth-1:0]            prev_period_ff, prev_period_in;
   logic [MagWidth-1:0]             prev_amplitude_ff, prev_amplitude_in;
   logic [CountWidth-1:0]           match_counter_ff, match_counter_in;
   logic signed [PositionWidth-1:0] held_effort_ff, held_effort_in;

   logic [MagWidth-1:0]             mag;
   logic signed [PositionWidth-1:0] mag_pos;
   logic [TimeWidth-1:0]            cur_period;
   logic signed [PositionWidth:0]   peak_span;
   logic [MagWidth-1:0]             cur_amplitude;
   logic [CountWidth-1:0]           count_inc;
   logic                            closed;
   match_type                       match;

   rfa_match u_match (
      .amplitude      (cur_amplitude),
      .prev_amplitude (prev_amplitude_ff),
      .period         (cur_period),
      .prev_period    (prev_period_ff),
      .amp_tol        (cfg.amplitude_tolerance),
      .per_tol        (cfg.period_tolerance),
      .match          (match)
   );

   always_comb begin
      mag        = (cfg.relay_height < cfg.effort_limit) ? cfg.relay_height
                                                         : cfg.effort_limit;
      mag_pos    = signed'({1'b0, mag});
      cur_period = req.sample_time - period_start_ff;
      peak_span  = signed'({2'b00, high_peak_ff}) -
                   {low_peak_ff[PositionWidth-1], low_peak_ff};
      cur_amplitude = peak_span[MagWidth:1];
      count_inc  = (match_counter_ff == COUNT_MAX) ? COUNT_MAX
                                                   : match_counter_ff + 1'b1;

      phase_mid         = phase_ff;
      high_peak_in      = high_peak_ff;
      low_peak_in       = low_peak_ff;
      period_start_in   = period_start_ff;
      prev_period_in    = prev_period_ff;
      prev_amplitude_in = prev_amplitude_ff;
      match_counter_in  = match_counter_ff;
      held_effort_in    = held_effort_ff;
      closed            = 1'b0;

      case (phase_ff)
         PHASE_SEEK_POS: begin
            if (req.position < 0) begin
               phase_mid = PHASE_SEEK_NEG;
            end
         end
         PHASE_SEEK_NEG: begin
            if (req.position > 0) begin
               closed    = 1'b1;
               phase_mid = PHASE_SEEK_POS;
               if (match.amp_ok && match.per_ok) begin
                  match_counter_in = count_inc;
                  if (count_inc >= cfg.cycles_needed) begin
                     phase_mid = PHASE_DONE;
                  end
               end else begin
                  match_counter_in = '0;
               end
               high_peak_in      = '0;
               low_peak_in       = '0;
               period_start_in   = req.sample_time;
               prev_period_in    = cur_period;
               prev_amplitude_in = cur_amplitude;
            end
         end
         default: begin
         end
      endcase

      // track the peak of the phase the sample ends up in
      case (phase_mid)
         PHASE_SEEK_POS: begin
            if (req.position > signed'({1'b0, high_peak_in})) begin
               high_peak_in = req.position[MagWidth-1:0];
            end
            held_effort_in = mag_pos;
         end
         PHASE_SEEK_NEG: begin
            if (req.position < low_peak_in) begin
               low_peak_in = req.position;
            end
            held_effort_in = -mag_pos;
         end
         default: begin
         end
      endcase

      phase_in = phase_mid;

      rsp.effort         = held_effort_in;
      rsp.phase          = phase_in;
      rsp.cycle_complete = closed;
      rsp.period         = prev_period_in;
      rsp.amplitude      = prev_amplitude_in;
      rsp.matched_count  = match_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PHASE_SEEK_POS;
         high_peak_ff      <= '0;
         low_peak_ff       <= '0;
         period_start_ff   <= '0;
         prev_period_ff    <= '0;
         prev_amplitude_ff <= '0;
         match_counter_ff  <= '0;
         held_effort_ff    <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         high_peak_ff      <= high_peak_in;
         low_peak_ff       <= low_peak_in;
         period_start_ff   <= period_start_in;
         prev_period_ff    <= prev_period_in;
         prev_amplitude_ff <= prev_amplitude_in;
         match_counter_ff  <= match_counter_in;
         held_effort_ff    <= held_effort_in;
      end
   end

endmodule
